FILE: rtl/mrr_pkg.sv
// Package for the Modbus RTU response receiver.
// Holds the item types, the parser phases, the protocol constants and the CRC-16 byte fold.
// No dependencies; every other file of the block imports it.
package mrr_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_write_ack;
    logic       crc_ok;
    logic [8:0] frame_length;
    logic [7:0] current_area;
    logic [7:0] outer_zone;
    logic [7:0] middle_zone;
    logic [7:0] inner_zone;
    logic       near_warning;
    logic       far_warning;
    logic [7:0] fault_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] idle_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_FUNC  = 2'd1,
    PH_READ  = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_IDLE = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] REG_SLAVE_ADDRESS = 8'd0;
  localparam logic [7:0] REG_IDLE_LIMIT    = 8'd1;

  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd1;
  localparam logic [7:0] IDLE_LIMIT_RESET    = 8'd10;

  // Function codes and frame geometry
  localparam logic [7:0] FN_READ         = 8'h04;
  localparam logic [7:0] FN_WRITE        = 8'h10;
  localparam logic [8:0] WRITE_FRAME_LEN = 9'd8;
  localparam logic [8:0] READ_OVERHEAD   = 9'd5;
  localparam logic [8:0] CRC_START_POS   = 9'd2;

  // Byte positions within a read frame
  localparam logic [8:0] POS_COUNT = 9'd2;
  localparam logic [8:0] POS_AREA  = 9'd4;
  localparam logic [8:0] POS_OUTER = 9'd6;
  localparam logic [8:0] POS_MID   = 9'd8;
  localparam logic [8:0] POS_INNER = 9'd10;
  localparam logic [8:0] POS_FAULT = 9'd12;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // One byte through the reflected CRC-16, eight shift steps unrolled
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/modbus_rtu_response_receiver_top.sv
// Top level of the Modbus RTU response receiver.
// Depends on mrr_pkg, mrr_cfg_regs, mrr_parser and mrr_out_reg.
//
// Usage:
//   byte channel   (byte_valid/byte_ready/byte_item): one received byte or one idle
//                  tick per item.
//   result channel (result_valid/result_ready/result_item): one item per completed
//                  response frame from the configured slave (function 0x04 or 0x10).
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 slave address,
//                  index 1 idle limit; always ready, unknown indexes are dropped.
// Throughput is one input item per cycle while byte_ready is high: the CRC-16 byte
// fold, field capture and frame-end check all sit in combinational logic between the
// parser state and the result register. A result appears on result_valid in the
// cycle after the item that ends the frame is accepted.
// byte_ready stays high while the result register is empty or being emptied in the
// same cycle; while a result waits on a stalled receiver, byte_ready is low.
// Synchronous reset returns the parser to the address hunt, empties the result
// register and sets slave address 1 and idle limit 10.
module modbus_rtu_response_receiver_top
  import mrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  in_item_t   byte_item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_item_t  result_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t      cfg;
  logic      take;
  logic      res_fire;
  out_item_t res;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !result_valid || result_ready;
  assign take       = byte_valid && byte_ready;

  mrr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mrr_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (byte_item),
    .cfg      (cfg),
    .res_fire (res_fire),
    .res      (res)
  );

  mrr_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (res_fire),
    .din   (res),
    .valid (result_valid),
    .ready (result_ready),
    .dout  (result_item)
  );

endmodule

FILE: rtl/mrr_cfg_regs.sv
// Configuration registers of the Modbus RTU response receiver.
// Depends on mrr_pkg for the register indexes and reset values.
module mrr_cfg_regs
  import mrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] wr_index,
  input  logic [7:0] wr_data,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address <= SLAVE_ADDRESS_RESET;
      cfg.idle_limit    <= IDLE_LIMIT_RESET;
    end else if (wr_en) begin
      // writes to unknown indexes are dropped
      case (wr_index)
        REG_SLAVE_ADDRESS: cfg.slave_address <= wr_data;
        REG_IDLE_LIMIT:    cfg.idle_limit    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/mrr_parser.sv
// Frame parser: phase tracking, byte counting, CRC-16 with two-byte delay line, field capture.
// Depends on mrr_pkg for types, constants and crc_fold.
module mrr_parser
  import mrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      take,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_fire,
  output out_item_t res
);

  phase_t      phase, phase_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [8:0]  expected_length, expected_next;
  logic [15:0] running_crc, crc_next;
  logic [15:0] delayed_bytes, delayed_next;
  logic [7:0]  captured [5];
  logic [7:0]  captured_next [5];
  logic [7:0]  idle_ticks, idle_ticks_next;

  logic        is_byte, is_idle, idle_abort, addr_match, func_ok, bad_func, feed;
  logic        finish_read, finish_write;
  logic [7:0]  b, idle_inc;
  logic [8:0]  base_index, index_fed;
  logic [15:0] base_crc, base_delay;

  assign b        = item.data_byte;
  assign is_byte  = take && (item.command == CMD_BYTE);
  assign is_idle  = take && (item.command == CMD_IDLE);
  assign idle_inc = idle_ticks + 8'd1;
  assign idle_abort = is_idle && (idle_inc >= cfg.idle_limit);

  assign addr_match = (phase == PH_HUNT) && (b == cfg.slave_address);
  assign func_ok    = (phase == PH_FUNC) && ((b == FN_READ) || (b == FN_WRITE));
  assign bad_func   = is_byte && (phase == PH_FUNC) && !func_ok;
  assign feed = is_byte && (addr_match || func_ok || (phase == PH_READ) || (phase == PH_WRITE));

  // An address match restarts the frame state before the byte goes in
  assign base_index = addr_match ? 9'd0 : byte_index;
  assign base_crc   = addr_match ? CRC_INIT : running_crc;
  assign base_delay = addr_match ? 16'h0000 : delayed_bytes;
  assign index_fed  = base_index + 9'd1;

  always_comb begin
    crc_next      = (base_index >= CRC_START_POS) ? crc_fold(base_crc, base_delay[15:8]) : base_crc;
    delayed_next  = {base_delay[7:0], b};
    expected_next = addr_match ? 9'd0 : expected_length;
    for (int i = 0; i < 5; i++) begin
      captured_next[i] = addr_match ? 8'h00 : captured[i];
    end
    if (phase == PH_READ) begin
      case (byte_index)
        POS_COUNT: expected_next = {1'b0, b} + READ_OVERHEAD;
        POS_AREA:  captured_next[0] = b;
        POS_OUTER: captured_next[1] = b;
        POS_MID:   captured_next[2] = b;
        POS_INNER: captured_next[3] = b;
        POS_FAULT: captured_next[4] = b;
        default: ;
      endcase
    end
  end

  assign finish_read  = is_byte && (phase == PH_READ) && (index_fed >= expected_next);
  assign finish_write = is_byte && (phase == PH_WRITE) && (index_fed >= WRITE_FRAME_LEN);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (idle_abort) begin
      phase_next = PH_HUNT;
    end else if (is_byte) begin
      case (phase)
        PH_HUNT:  phase_next = addr_match ? PH_FUNC : PH_HUNT;
        PH_FUNC: begin
          if (b == FN_READ) begin
            phase_next = PH_READ;
          end else if (b == FN_WRITE) begin
            phase_next = PH_WRITE;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_READ:  phase_next = finish_read ? PH_HUNT : PH_READ;
        PH_WRITE: phase_next = finish_write ? PH_HUNT : PH_WRITE;
        default:  phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    if (feed) begin
      byte_index_next = (finish_read || finish_write) ? 9'd0 : index_fed;
    end else if (idle_abort || bad_func) begin
      byte_index_next = 9'd0;
    end else begin
      byte_index_next = byte_index;
    end
    if (is_idle) begin
      idle_ticks_next = idle_abort ? 8'd0 : idle_inc;
    end else if (is_byte) begin
      idle_ticks_next = 8'd0;
    end else begin
      idle_ticks_next = idle_ticks;
    end
  end

  // Result outputs
  always_comb begin
    res_fire         = finish_read || finish_write;
    res              = '0;
    res.is_write_ack = finish_write;
    res.crc_ok       = (crc_next[7:0] == delayed_next[15:8]) && (crc_next[15:8] == delayed_next[7:0]);
    res.frame_length = index_fed;
    if (!finish_write) begin
      res.current_area = captured_next[0];
      res.outer_zone   = captured_next[1];
      res.middle_zone  = captured_next[2];
      res.inner_zone   = captured_next[3];
      res.fault_code   = captured_next[4];
      res.near_warning = (captured_next[3] != 8'h00);
      res.far_warning  = (captured_next[1] != 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      byte_index      <= 9'd0;
      expected_length <= 9'd0;
      running_crc     <= CRC_INIT;
      delayed_bytes   <= 16'h0000;
      idle_ticks      <= 8'd0;
      for (int i = 0; i < 5; i++) begin
        captured[i] <= 8'h00;
      end
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
      idle_ticks <= idle_ticks_next;
      if (feed) begin
        expected_length <= expected_next;
        running_crc     <= crc_next;
        delayed_bytes   <= delayed_next;
        for (int i = 0; i < 5; i++) begin
          captured[i] <= captured_next[i];
        end
      end
    end
  end

endmodule

FILE: rtl/mrr_out_reg.sv
// Result register: holds one finished item until the downstream side takes it.
// Depends on mrr_pkg for the result item type.
module mrr_out_reg
  import mrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t din,
  output logic      valid,
  input  logic      ready,
  output out_item_t dout
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
